// File: hw/rtl/bhet_pkg.sv
// shared types, constants and count update function for the button hold tracker
package bhet_pkg;

	localparam int MAX_BUTTONS = 7;
	localparam int COUNT_W     = 8;
	localparam int BIT_SEL_W   = $clog2(COUNT_W);
	localparam int CFG_IDX_W   = 1;

	localparam logic [COUNT_W-1:0] IDLE_CODE     = 8'h00;
	localparam logic [COUNT_W-1:0] RELEASED_CODE = 8'hFF;
	localparam logic [COUNT_W-1:0] SAT_COUNT     = 8'hFE;

	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic                 load;
		logic                 step;
		logic [BIT_SEL_W-1:0] bit_sel;
		logic                 publish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctrl_stat_t;

	function automatic logic [COUNT_W-1:0] next_count(input logic [COUNT_W-1:0] c,
		input logic level);
		logic [COUNT_W-1:0] n;
		if (level) begin
			if (c == RELEASED_CODE) n = IDLE_CODE;
			else if (c >= SAT_COUNT) n = SAT_COUNT;
			else n = c + 8'd1;
		end else begin
			if (c == IDLE_CODE || c == RELEASED_CODE) n = IDLE_CODE;
			else n = RELEASED_CODE;
		end
		return n;
	endfunction

endpackage

// File: hw/rtl/bhet_ctrl.sv
// controller state machine sequencing count update, remainder steps and result publish
module bhet_ctrl
	import bhet_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	state_t               state_q;
	state_t               state_d;
	logic [BIT_SEL_W-1:0] bit_q;
	logic [BIT_SEL_W-1:0] bit_d;

	assign in_stall    = (state_q != ST_IDLE);
	assign cmd.load    = (state_q == ST_IDLE) && in_valid;
	assign cmd.step    = (state_q == ST_DIV);
	assign cmd.bit_sel = bit_q;
	assign cmd.publish = (state_q == ST_DONE) && stat.out_free;

	always_comb begin
		state_d = state_q;
		bit_d   = bit_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DIV;
					bit_d   = BIT_SEL_W'(COUNT_W - 1);
				end
			end
			ST_DIV: begin
				bit_d = bit_q - BIT_SEL_W'(1);
				if (bit_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
		end
	end

	a_load_enters_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_DIV) && (bit_q == BIT_SEL_W'(COUNT_W - 1)))
		else $error("load did not start the remainder steps");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && bit_q == '0) |=> (state_q == ST_DONE))
		else $error("last remainder step did not reach done");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register lost one-hot form");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_DONE) |-> !cmd.load)
		else $error("transaction accepted while busy");

endmodule

// File: hw/rtl/bhet_datapath.sv
// hold counts, per-button remainder lanes, configuration and output register
module bhet_datapath
	import bhet_pkg::*;
#(
	parameter int BUTTON_COUNT = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COUNT_W-1:0]     cfg_data,
	input  logic [MAX_BUTTONS-1:0] button_levels,
	input  ctrl_cmd_t              cmd,
	output ctrl_stat_t             stat,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [MAX_BUTTONS-1:0] pressed_mask,
	output logic [MAX_BUTTONS-1:0] released_mask,
	output logic [MAX_BUTTONS-1:0] held_event_mask,
	output logic [MAX_BUTTONS-1:0] repeat_mask,
	output logic [COUNT_W-1:0]     hold_time [MAX_BUTTONS]
);

	logic [COUNT_W-1:0]     thr_q;
	logic [COUNT_W-1:0]     period_q;
	logic [COUNT_W-1:0]     count_q [MAX_BUTTONS];
	logic [COUNT_W-1:0]     rem_q   [MAX_BUTTONS];
	logic                   out_valid_q;
	logic [MAX_BUTTONS-1:0] pressed_q;
	logic [MAX_BUTTONS-1:0] released_q;
	logic [MAX_BUTTONS-1:0] held_q;
	logic [MAX_BUTTONS-1:0] repeat_q;
	logic [COUNT_W-1:0]     hold_time_q [MAX_BUTTONS];
	logic [COUNT_W:0]       target;
	logic                   short_period;

	assign stat.out_free = !out_valid_q || !out_stall;
	assign target        = {1'b0, thr_q} + 9'd1;
	assign short_period  = (period_q <= 8'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 8'd1;
			period_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HOLD_THRESHOLD: thr_q    <= cfg_data;
				CFG_REPEAT_PERIOD:  period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold counts for the lanes that exist
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BUTTONS; i++) count_q[i] <= IDLE_CODE;
		end else if (cmd.load) begin
			for (int i = 0; i < MAX_BUTTONS; i++) begin
				if (i < BUTTON_COUNT) count_q[i] <= next_count(count_q[i], button_levels[i]);
			end
		end
	end

	// restoring remainder, one count bit per step, all lanes together
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_BUTTONS; i++) begin
			logic [COUNT_W:0] sh;
			sh = {rem_q[i], count_q[i][cmd.bit_sel]};
			if (cmd.load) begin
				rem_q[i] <= '0;
			end else if (cmd.step) begin
				if (sh >= {1'b0, period_q}) rem_q[i] <= COUNT_W'(sh - {1'b0, period_q});
				else rem_q[i] <= sh[COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			for (int i = 0; i < MAX_BUTTONS; i++) begin
				logic live;
				live = (count_q[i] != IDLE_CODE) && (count_q[i] != RELEASED_CODE);
				pressed_q[i]   <= (count_q[i] == 8'd1);
				released_q[i]  <= (count_q[i] == RELEASED_CODE);
				held_q[i]      <= ({1'b0, count_q[i]} == target);
				repeat_q[i]    <= live && (short_period || rem_q[i] == 8'd1);
				hold_time_q[i] <= (count_q[i] == RELEASED_CODE) ? IDLE_CODE : count_q[i];
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign pressed_mask    = pressed_q;
	assign released_mask   = released_q;
	assign held_event_mask = held_q;
	assign repeat_mask     = repeat_q;
	assign hold_time       = hold_time_q;

	a_rise_after_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.publish))
		else $error("result appeared without publish");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.publish)
		else $error("stalled result overwritten");

endmodule

// File: hw/rtl/button_hold_event_tracker_core.sv
// top level of the button hold event tracker
//
// channel   direction  handshake            payload
// cfg       in         cfg_we               cfg_index, cfg_data
// in        in         in_valid / in_stall  button_levels
// out       out        out_valid / out_stall pressed, released, held, repeat masks, hold_time_0..6
//
// a transaction is accepted together with its count update, then eight restoring
// remainder steps run (one count bit each, all buttons in parallel) and a publish
// loads the output register; the input stays stalled from acceptance until that
// result is published
// a stalled result holds publish back and the input stalls until it is published
// reset clears all hold counts to idle and sets both registers to 1
module button_hold_event_tracker_core
	import bhet_pkg::*;
#(
	parameter int BUTTON_COUNT = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COUNT_W-1:0]     cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [MAX_BUTTONS-1:0] button_levels,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [MAX_BUTTONS-1:0] pressed_mask,
	output logic [MAX_BUTTONS-1:0] released_mask,
	output logic [MAX_BUTTONS-1:0] held_event_mask,
	output logic [MAX_BUTTONS-1:0] repeat_mask,
	output logic [COUNT_W-1:0]     hold_time_0,
	output logic [COUNT_W-1:0]     hold_time_1,
	output logic [COUNT_W-1:0]     hold_time_2,
	output logic [COUNT_W-1:0]     hold_time_3,
	output logic [COUNT_W-1:0]     hold_time_4,
	output logic [COUNT_W-1:0]     hold_time_5,
	output logic [COUNT_W-1:0]     hold_time_6
);

	ctrl_cmd_t          cmd;
	ctrl_stat_t         stat;
	logic [COUNT_W-1:0] hold_time [MAX_BUTTONS];

	bhet_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bhet_datapath #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.button_levels   (button_levels),
		.cmd             (cmd),
		.stat            (stat),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.pressed_mask    (pressed_mask),
		.released_mask   (released_mask),
		.held_event_mask (held_event_mask),
		.repeat_mask     (repeat_mask),
		.hold_time       (hold_time)
	);

	assign hold_time_0 = hold_time[0];
	assign hold_time_1 = hold_time[1];
	assign hold_time_2 = hold_time[2];
	assign hold_time_3 = hold_time[3];
	assign hold_time_4 = hold_time[4];
	assign hold_time_5 = hold_time[5];
	assign hold_time_6 = hold_time[6];

endmodule

// File: verif/button_hold_event_tracker_tb.sv
// self-checking testbench for the button hold event tracker core
module tb
	import bhet_pkg::*;
();

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 5;
	localparam int MAX_GAP       = 16;
	localparam int LONG_HOLD_OFF = 200;
	localparam int HOLD_OFF_AT   = 100;
	localparam int SETTLE_CYCLES = 12;
	localparam int RUN_LIMIT     = 3_000_000;

	typedef struct packed {
		logic [MAX_BUTTONS-1:0]              pressed;
		logic [MAX_BUTTONS-1:0]              released;
		logic [MAX_BUTTONS-1:0]              held;
		logic [MAX_BUTTONS-1:0]              rpt;
		logic [MAX_BUTTONS-1:0][COUNT_W-1:0] hold_time;
	} tick_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_HOLD_THRESHOLD;
	logic [COUNT_W-1:0]     cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [MAX_BUTTONS-1:0] button_levels = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [MAX_BUTTONS-1:0] pressed_mask;
	logic [MAX_BUTTONS-1:0] released_mask;
	logic [MAX_BUTTONS-1:0] held_event_mask;
	logic [MAX_BUTTONS-1:0] repeat_mask;
	logic [COUNT_W-1:0]     hold_time_0;
	logic [COUNT_W-1:0]     hold_time_1;
	logic [COUNT_W-1:0]     hold_time_2;
	logic [COUNT_W-1:0]     hold_time_3;
	logic [COUNT_W-1:0]     hold_time_4;
	logic [COUNT_W-1:0]     hold_time_5;
	logic [COUNT_W-1:0]     hold_time_6;

	logic [MAX_BUTTONS-1:0] frame_q[$];
	tick_result_t           tick_q[$];
	logic [COUNT_W-1:0]     hold_count[MAX_BUTTONS];
	logic [COUNT_W-1:0]     hold_threshold = 8'd1;
	logic [COUNT_W-1:0]     repeat_period = 8'd1;
	logic [MAX_BUTTONS-1:0] level_track = '0;
	int                     fail_count = 0;
	int                     ticks_seen = 0;
	int                     frame_gap = 0;
	int                     stall_left = 0;
	logic                   frame_calm = 1'b0;
	logic                   tick_calm = 1'b0;

	button_hold_event_tracker_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.button_levels   (button_levels),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pressed_mask    (pressed_mask),
		.released_mask   (released_mask),
		.held_event_mask (held_event_mask),
		.repeat_mask     (repeat_mask),
		.hold_time_0     (hold_time_0),
		.hold_time_1     (hold_time_1),
		.hold_time_2     (hold_time_2),
		.hold_time_3     (hold_time_3),
		.hold_time_4     (hold_time_4),
		.hold_time_5     (hold_time_5),
		.hold_time_6     (hold_time_6)
	);

	always #(CLK_HALF) clk = ~clk;

	initial begin
		foreach (hold_count[b]) hold_count[b] = IDLE_CODE;
	end

	// advances the hold counts by one frame and derives the event masks
	function automatic tick_result_t frame_update(logic [MAX_BUTTONS-1:0] levels);
		tick_result_t       r;
		logic [COUNT_W-1:0] c;
		r = '0;
		for (int b = 0; b < MAX_BUTTONS; b++) begin
			c = hold_count[b];
			if (levels[b]) begin
				if (c == RELEASED_CODE) c = IDLE_CODE;
				else if (c < SAT_COUNT) c = c + 8'd1;
				else c = SAT_COUNT;
			end else if (c != IDLE_CODE) begin
				c = (c == RELEASED_CODE) ? IDLE_CODE : RELEASED_CODE;
			end
			hold_count[b] = c;
			r.pressed[b] = (c == 8'd1);
			r.released[b] = (c == RELEASED_CODE);
			r.held[b] = ({1'b0, c} == {1'b0, hold_threshold} + 9'd1);
			r.rpt[b] = (c != IDLE_CODE) && (c != RELEASED_CODE)
				&& ((repeat_period <= 8'd1) || (c % repeat_period == 8'd1));
			r.hold_time[b] = (c == RELEASED_CODE) ? IDLE_CODE : c;
		end
		return r;
	endfunction

	task automatic compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// input side: one frame per transaction, random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			frame_gap <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) tick_q.push_back(frame_update(button_levels));
			if (frame_gap != 0) begin
				in_valid <= 1'b0;
				frame_gap <= frame_gap - 1;
			end else if (frame_q.size() != 0) begin
				in_valid <= 1'b1;
				button_levels <= frame_q.pop_front();
				if ($urandom_range(0, 31) == 0) frame_calm = ~frame_calm;
				frame_gap <= frame_calm ? 0 : $urandom_range(0, MAX_GAP);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: check each transaction, then stall for a random stretch
	always @(posedge clk or negedge arst_n) begin : rx
		tick_result_t                        want;
		logic [MAX_BUTTONS-1:0][COUNT_W-1:0] seen_hold;
		int                                  wait_n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			wait_n = stall_left;
			if (out_valid && !out_stall) begin
				ticks_seen++;
				if (tick_q.size() == 0) begin
					$error("unexpected result transaction");
					fail_count++;
				end else begin
					want = tick_q.pop_front();
					seen_hold = {hold_time_6, hold_time_5, hold_time_4, hold_time_3,
						hold_time_2, hold_time_1, hold_time_0};
					compare_field("pressed_mask", want.pressed, pressed_mask);
					compare_field("released_mask", want.released, released_mask);
					compare_field("held_event_mask", want.held, held_event_mask);
					compare_field("repeat_mask", want.rpt, repeat_mask);
					for (int b = 0; b < MAX_BUTTONS; b++)
						compare_field($sformatf("hold_time_%0d", b), want.hold_time[b],
							seen_hold[b]);
				end
				if ($urandom_range(0, 31) == 0) tick_calm = ~tick_calm;
				wait_n = tick_calm ? 0 : $urandom_range(0, MAX_GAP);
				if (ticks_seen == HOLD_OFF_AT) wait_n = LONG_HOLD_OFF;
			end
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				stall_left <= wait_n - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= 0;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HOLD_THRESHOLD) hold_threshold = val;
		else repeat_period = val;
	endtask

	// waits until every frame is sent and every result has come back
	task automatic drain();
		while (frame_q.size() != 0 || in_valid || tick_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_frames(int count, int flip_odds, logic [MAX_BUTTONS-1:0] held_down);
		for (int k = 0; k < count; k++) begin
			for (int b = 0; b < MAX_BUTTONS; b++) begin
				if (held_down[b]) level_track[b] = 1'b1;
				else if ($urandom_range(0, flip_odds - 1) == 0) level_track[b] = ~level_track[b];
			end
			if ($urandom_range(0, 15) == 0)
				frame_q.push_back(7'($urandom_range(0, 127)) | held_down);
			else frame_q.push_back(level_track);
		end
	endtask

	initial begin
		logic [MAX_BUTTONS-1:0] directed[16] = '{7'h00, 7'h7F, 7'h7F, 7'h7F, 7'h00, 7'h00,
			7'h55, 7'h2A, 7'h2A, 7'h00, 7'h7F, 7'h00, 7'h7F, 7'h7F, 7'h01, 7'h40};
		logic [MAX_BUTTONS-1:0] long_mask;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: press, held, release, press while just released
		foreach (directed[k]) frame_q.push_back(directed[k]);
		drain();

		// held event on the first held frame, repeat every frame
		write_reg(CFG_HOLD_THRESHOLD, 8'd0);
		write_reg(CFG_REPEAT_PERIOD, 8'd0);
		queue_frames(30, 3, '0);
		drain();

		// held event never fires, repeat only on the first frame
		write_reg(CFG_HOLD_THRESHOLD, 8'd255);
		write_reg(CFG_REPEAT_PERIOD, 8'd255);
		queue_frames(30, 2, '0);
		drain();

		// long holds up to saturation
		long_mask = (7'd1 << $urandom_range(0, MAX_BUTTONS - 1))
			| (7'($urandom_range(0, 127)) & 7'($urandom_range(0, 127)));
		write_reg(CFG_HOLD_THRESHOLD, 8'd253);
		write_reg(CFG_REPEAT_PERIOD, 8'($urandom_range(2, 16)));
		queue_frames(262, 8, long_mask);
		drain();

		// held event together with release
		write_reg(CFG_HOLD_THRESHOLD, 8'd254);
		write_reg(CFG_REPEAT_PERIOD, 8'd254);
		queue_frames(30, 4, '0);
		drain();

		repeat (2) begin
			write_reg(CFG_HOLD_THRESHOLD, 8'($urandom_range(1, 30)));
			write_reg(CFG_REPEAT_PERIOD, 8'($urandom_range(2, 12)));
			queue_frames(25, 24, '0);
			drain();
		end

		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/bhet_pkg.sv
hw/rtl/bhet_ctrl.sv
hw/rtl/bhet_datapath.sv
hw/rtl/button_hold_event_tracker_core.sv
verif/button_hold_event_tracker_tb.sv
